FILE: rtl/sib_pkg.sv
package sib_pkg;

    localparam int DepthDefault = 16;

    // opcodes of the input channel
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FLUSHED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // one stored record
    typedef struct packed {
        logic signed [31:0] key;
        logic [47:0]        plate;
        logic [63:0]        brand_low;
        logic [15:0]        brand_high;
    } record_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic ins;   // insert the new record this cycle
        logic rot;   // rotate the occupied cells down by one place
    } cell_ctrl_t;

endpackage

FILE: rtl/sib_cell.sv
module sib_cell
    import sib_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occ,
    input  logic       tail,
    input  logic       prev_keep,
    input  record_t    new_rec,
    input  record_t    prev_rec,
    input  record_t    next_rec,
    input  record_t    head_rec,
    output logic       keep,
    output record_t    rec
);

    record_t rec_reg;
    record_t rec_next;

    // entry stays put when it is occupied and not greater than the new key
    assign keep = occ && !(rec_reg.key > new_rec.key);
    assign rec  = rec_reg;

    always_comb begin
        rec_next = rec_reg;
        if (ctrl.ins) begin
            if (keep) begin
                rec_next = rec_reg;
            end else if (prev_keep) begin
                rec_next = new_rec;
            end else begin
                rec_next = prev_rec;
            end
        end else if (ctrl.rot) begin
            rec_next = tail ? head_rec : next_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

FILE: rtl/sorted_insert_buffer.sv
// channel | direction | ports                                          | handshake
// input   | in        | s_opcode s_car_value s_plate_text s_brand_*    | s_valid / s_ready
// result  | out       | m_status m_entry_total m_out_* m_last          | m_valid / m_ready
//
// on an insert every cell compares its key with the new key and
// either holds, shifts up from its lower neighbor or loads the new record
// a flush gives entry_count results from the FLUSH state, one per cycle
// while m_ready is high; each step reads cell 0 and rotates the occupied cells
// down, so the store is whole again after the last transfer; s_ready is low
// for the whole flush
// reset (aresetn low, synchronous) empties the store and drops m_valid
// a stalled result holds the output register; a new item is taken in the same
// cycle that the waiting result is transferred
module sorted_insert_buffer
    import sib_pkg::*;
#(
    parameter int DEPTH = DepthDefault,
    localparam int CntW = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic signed [31:0]  s_car_value,
    input  logic [47:0]         s_plate_text,
    input  logic [63:0]         s_brand_low,
    input  logic [15:0]         s_brand_high,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [CntW-1:0]     m_entry_total,
    output logic signed [31:0]  m_out_value,
    output logic [47:0]         m_out_plate,
    output logic [63:0]         m_out_brand_low,
    output logic [15:0]         m_out_brand_high,
    output logic                m_last
);

    typedef enum logic {
        IDLE,
        FLUSH
    } state_t;

    state_t          state_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] step_reg;     // flush results already handed to the output

    logic            m_valid_reg;
    logic [1:0]      status_reg;
    logic [CntW-1:0] total_reg;
    record_t         out_rec_reg;
    logic            last_reg;

    logic            out_free;     // output register empty or being transferred
    logic            s_xfer;
    logic            full;
    logic            flush_last;
    cell_ctrl_t      ctrl;
    record_t         new_rec;

    logic    [DEPTH-1:0] occ;
    logic    [DEPTH-1:0] keep;
    record_t             rec_q [DEPTH];

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == IDLE) && out_free;
    assign s_xfer     = s_valid && s_ready;
    assign full       = (count_reg == CntW'(DEPTH));
    assign flush_last = (step_reg == count_reg - CntW'(1));

    assign new_rec.key        = s_car_value;
    assign new_rec.plate      = s_plate_text;
    assign new_rec.brand_low  = s_brand_low;
    assign new_rec.brand_high = s_brand_high;

    // insert only on an accepted insert into a store with room
    assign ctrl.ins = s_xfer && (s_opcode == OP_INSERT) && !full;
    assign ctrl.rot = (state_reg == FLUSH) && out_free;

    // thermometer of occupied cells
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occ[i] = (CntW'(i) < count_reg);
        end
    end

    // row of cells, cell 0 holds the lowest key
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic    prev_keep;
        logic    tail;
        record_t prev_rec;
        record_t next_rec;

        if (i == 0) begin : g_first
            assign prev_keep = 1'b1;
            assign prev_rec  = new_rec;
        end else begin : g_mid
            assign prev_keep = keep[i-1];
            assign prev_rec  = rec_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_rec = rec_q[i];
            assign tail     = occ[i];
        end else begin : g_inner
            assign next_rec = rec_q[i+1];
            assign tail     = occ[i] && !occ[i+1];
        end

        sib_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occ       (occ[i]),
            .tail      (tail),
            .prev_keep (prev_keep),
            .new_rec   (new_rec),
            .prev_rec  (prev_rec),
            .next_rec  (next_rec),
            .head_rec  (rec_q[0]),
            .keep      (keep[i]),
            .rec       (rec_q[i])
        );
    end

    // sequencer, entry count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_xfer) begin
                        out_rec_reg <= '0;
                        last_reg    <= 1'b1;
                        if (s_opcode == OP_INSERT) begin
                            m_valid_reg <= 1'b1;
                            if (full) begin
                                status_reg <= ST_FULL;
                                total_reg  <= count_reg;
                            end else begin
                                status_reg <= ST_INSERTED;
                                total_reg  <= count_reg + CntW'(1);
                                count_reg  <= count_reg + CntW'(1);
                            end
                        end else if (count_reg == '0) begin
                            m_valid_reg <= 1'b1;
                            status_reg  <= ST_EMPTY;
                            total_reg   <= '0;
                        end else begin
                            // results come from the flush state
                            m_valid_reg <= 1'b0;
                            step_reg    <= '0;
                            state_reg   <= FLUSH;
                        end
                    end else if (out_free) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                FLUSH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        status_reg  <= ST_FLUSHED;
                        total_reg   <= count_reg;
                        out_rec_reg <= rec_q[0];
                        last_reg    <= flush_last;
                        step_reg    <= step_reg + CntW'(1);
                        if (flush_last) begin
                            state_reg <= IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_entry_total    = total_reg;
    assign m_out_value      = out_rec_reg.key;
    assign m_out_plate      = out_rec_reg.plate;
    assign m_out_brand_low  = out_rec_reg.brand_low;
    assign m_out_brand_high = out_rec_reg.brand_high;
    assign m_last           = last_reg;

    // store never overfills
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(DEPTH))
        else $error("entry count above depth");

    // insert and rotate never collide
    a_ctrl_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.ins && ctrl.rot))
        else $error("insert during flush rotation");

    // a successful insert grows the store by exactly one
    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("entry count did not advance on insert");

    // count holds through a flush
    a_flush_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FLUSH) |=> $stable(count_reg))
        else $error("entry count changed during flush");

endmodule

FILE: tb/sorted_insert_buffer_test.sv
`timescale 1ns / 1ps

module sorted_insert_buffer_test;
    import sib_pkg::*;

    localparam int Depth          = DepthDefault;
    localparam int CountW         = $clog2(Depth + 1);
    localparam int RandomPerPhase = 143;
    localparam int CycleLimit     = 300000;
    // drain time past the last transfer so a stray result still shows up
    localparam int DrainCycles    = 40;

    // one result transfer as seen on the m_ channel
    typedef struct packed {
        logic [1:0]         status;
        logic [CountW-1:0]  total;
        logic signed [31:0] value;
        logic [47:0]        plate;
        logic [63:0]        brand_low;
        logic [15:0]        brand_high;
        logic               last;
    } sort_result_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic         op;
        record_t      rec;
        bit           typed;
        sort_result_t typed_result;
    } stim_row_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_opcode         = OP_INSERT;
    logic signed [31:0]    s_car_value      = '0;
    logic [47:0]           s_plate_text     = '0;
    logic [63:0]           s_brand_low      = '0;
    logic [15:0]           s_brand_high     = '0;
    logic                  m_ready          = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [1:0]            m_status;
    logic [CountW-1:0]     m_entry_total;
    logic signed [31:0]    m_out_value;
    logic [47:0]           m_out_plate;
    logic [63:0]           m_out_brand_low;
    logic [15:0]           m_out_brand_high;
    logic                  m_last;

    // idle rates in percent, changed from phase to phase
    int                    send_idle_pct    = 0;
    int                    recv_idle_pct    = 0;
    int                    error_count      = 0;
    int                    cycle_count      = 0;

    // shadow copy of the sorted store
    record_t               sorted_records [Depth];
    int                    record_count     = 0;
    sort_result_t          step_results [$];
    sort_result_t          expected_entries [$];
    stim_row_t             directed_rows [$];

    sorted_insert_buffer #(
        .DEPTH(Depth)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_car_value      (s_car_value),
        .s_plate_text     (s_plate_text),
        .s_brand_low      (s_brand_low),
        .s_brand_high     (s_brand_high),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_total    (m_entry_total),
        .m_out_value      (m_out_value),
        .m_out_plate      (m_out_plate),
        .m_out_brand_low  (m_out_brand_low),
        .m_out_brand_high (m_out_brand_high),
        .m_last           (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic sort_result_t make_result(input logic [1:0] status, input int total,
                                                 input record_t rec, input logic last);
        sort_result_t r;
        r.status     = status;
        r.total      = CountW'(total);
        r.value      = rec.key;
        r.plate      = rec.plate;
        r.brand_low  = rec.brand_low;
        r.brand_high = rec.brand_high;
        r.last       = last;
        return r;
    endfunction

    // insertion sort on the shadow store; fills step_results with what the
    // item should produce, in transfer order
    function automatic void predict_sorted_step(input logic op, input record_t rec);
        int pos;
        step_results.delete();
        if (op == OP_INSERT) begin
            if (record_count >= Depth) begin
                // full store, record dropped
                step_results.push_back(make_result(ST_FULL, record_count, '0, 1'b1));
            end else begin
                // greater keys move up; equal keys stay below the new one
                pos = record_count;
                while (pos > 0 && sorted_records[pos-1].key > rec.key) begin
                    sorted_records[pos] = sorted_records[pos-1];
                    pos--;
                end
                sorted_records[pos] = rec;
                record_count++;
                step_results.push_back(make_result(ST_INSERTED, record_count, '0, 1'b1));
            end
        end else if (record_count == 0) begin
            step_results.push_back(make_result(ST_EMPTY, 0, '0, 1'b1));
        end else begin
            // flush walks the whole store, store kept as is
            for (int k = 0; k < record_count; k++) begin
                step_results.push_back(make_result(ST_FLUSHED, record_count,
                                                   sorted_records[k], k == record_count - 1));
            end
        end
    endfunction

    function automatic void add_row(input logic op, input logic signed [31:0] key,
                                    input logic [47:0] plate, input logic [63:0] blo,
                                    input logic [15:0] bhi, input bit typed,
                                    input logic [1:0] status, input int total);
        stim_row_t entry;
        entry.op             = op;
        entry.rec.key        = key;
        entry.rec.plate      = plate;
        entry.rec.brand_low  = blo;
        entry.rec.brand_high = bhi;
        entry.typed          = typed;
        entry.typed_result   = make_result(status, total, '0, 1'b1);
        directed_rows.push_back(entry);
    endfunction

    // drive one item, hold it until the transfer, then record what it should cause
    task automatic send_item(input logic op, input record_t rec, input bit typed,
                             input sort_result_t typed_result);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_car_value  <= rec.key;
        s_plate_text <= rec.plate;
        s_brand_low  <= rec.brand_low;
        s_brand_high <= rec.brand_high;
        do @(posedge aclk); while (!s_ready);
        predict_sorted_step(op, rec);
        if (typed) begin
            expected_entries.push_back(typed_result);
        end else begin
            foreach (step_results[i]) expected_entries.push_back(step_results[i]);
        end
    endtask

    task automatic send_random_item();
        logic    op;
        record_t rec;
        op = ($urandom_range(99) < 25) ? OP_FLUSH : OP_INSERT;
        // keys: full range, the extremes, or a narrow band full of ties
        case ($urandom_range(3))
            0: rec.key = $urandom;
            1: begin
                case ($urandom_range(3))
                    0: rec.key = 32'sh8000_0000;
                    1: rec.key = 32'sh7fff_ffff;
                    2: rec.key = 32'sd0;
                    default: rec.key = -32'sd1;
                endcase
            end
            2: rec.key = $signed(32'($urandom_range(8))) - 32'sd4;
            default: rec.key = $urandom;
        endcase
        rec.plate      = {16'($urandom), 32'($urandom)};
        rec.brand_low  = {32'($urandom), 32'($urandom)};
        rec.brand_high = 16'($urandom);
        send_item(op, rec, 1'b0, '0);
    endtask

    // sender goes quiet until every outstanding result has been transferred
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_entries.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result side: every transfer against the oldest expectation
    always @(posedge aclk) begin : result_check
        sort_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected result, status %0d total %0d value %0d",
                         $time, m_status, m_entry_total, m_out_value);
                error_count++;
            end else begin
                want = expected_entries.pop_front();
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("entry_total", 64'(want.total), 64'(m_entry_total));
                check_field("out_value", 64'(want.value), 64'(m_out_value));
                check_field("out_plate", 64'(want.plate), 64'(m_out_plate));
                check_field("out_brand_low", want.brand_low, m_out_brand_low);
                check_field("out_brand_high", 64'(want.brand_high), 64'(m_out_brand_high));
                check_field("last", 64'(want.last), 64'(m_last));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("sorted_insert_buffer_test: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // flush before anything is stored
        add_row(OP_FLUSH, 32'sd0, '0, '0, '0, 1'b1, ST_EMPTY, 0);
        // key extremes with all-ones and all-zeros payloads
        add_row(OP_INSERT, 32'sh7fff_ffff, '1, '1, '1, 1'b1, ST_INSERTED, 1);
        add_row(OP_INSERT, 32'sh8000_0000, '0, '0, '0, 1'b1, ST_INSERTED, 2);
        // two equal keys, order of arrival must survive
        add_row(OP_INSERT, 32'sd0, 48'h414243_313233, 64'h5345_4441_4e5f_4f4e,
                16'h4531, 1'b1, ST_INSERTED, 3);
        add_row(OP_INSERT, 32'sd0, 48'h585958_393837, 64'h434f_5550_455f_5457,
                16'h4f32, 1'b1, ST_INSERTED, 4);
        add_row(OP_INSERT, -32'sd1, 48'h0000_0000_0006, 64'h6, 16'h6, 1'b1, ST_INSERTED, 5);
        // partial store flush
        add_row(OP_FLUSH, 32'sd0, '0, '0, '0, 1'b0, ST_FLUSHED, 0);
        // fill to the top, ties against both extremes included
        add_row(OP_INSERT, 32'sd7, 48'h7, 64'h7, 16'h7, 1'b1, ST_INSERTED, 6);
        add_row(OP_INSERT, -32'sd7, 48'h8, 64'h8, 16'h8, 1'b1, ST_INSERTED, 7);
        add_row(OP_INSERT, 32'sd0, 48'h9, 64'h9, 16'h9, 1'b1, ST_INSERTED, 8);
        add_row(OP_INSERT, 32'sd7, 48'ha, 64'ha, 16'ha, 1'b1, ST_INSERTED, 9);
        add_row(OP_INSERT, 32'sh7fff_ffff, 48'hb, 64'hb, 16'hb, 1'b1, ST_INSERTED, 10);
        add_row(OP_INSERT, 32'sh8000_0000, 48'hc, 64'hc, 16'hc, 1'b1, ST_INSERTED, 11);
        add_row(OP_INSERT, 32'sd42, 48'hd, 64'hd, 16'hd, 1'b1, ST_INSERTED, 12);
        add_row(OP_INSERT, -32'sd42, 48'he, 64'he, 16'he, 1'b1, ST_INSERTED, 13);
        add_row(OP_INSERT, 32'sd1, 48'hf, 64'hf, 16'hf, 1'b1, ST_INSERTED, 14);
        add_row(OP_INSERT, -32'sd1, 48'h10, 64'h10, 16'h10, 1'b1, ST_INSERTED, 15);
        add_row(OP_INSERT, 32'sd100, 48'h11, 64'h11, 16'h11, 1'b1, ST_INSERTED, 16);
        // store full, records turned away
        add_row(OP_INSERT, 32'sd5, 48'h12, 64'h12, 16'h12, 1'b1, ST_FULL, 16);
        add_row(OP_INSERT, 32'sh8000_0000, '1, '1, '1, 1'b1, ST_FULL, 16);
        // full store flush, sixteen transfers
        add_row(OP_FLUSH, 32'sd0, '0, '0, '0, 1'b0, ST_FLUSHED, 0);

        // phase one: sender idles less than the receiver
        send_idle_pct = 35;
        recv_idle_pct = 45;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].rec, directed_rows[i].typed,
                      directed_rows[i].typed_result);
        end
        wait_all_results();
        repeat (RandomPerPhase) send_random_item();
        wait_all_results();

        // phase two: roles swapped
        send_idle_pct = 45;
        recv_idle_pct = 35;
        repeat (RandomPerPhase) send_random_item();

        // phase three: back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RandomPerPhase) send_random_item();

        wait_all_results();
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("sorted_insert_buffer_test: done, clean");
        end else begin
            $display("sorted_insert_buffer_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sib_pkg.sv
rtl/sib_cell.sv
rtl/sorted_insert_buffer.sv
tb/sorted_insert_buffer_test.sv
